// ===== rtl/cursor_line_editor_defines.svh =====
// Assertion macros shared by the line editor checker.
`ifndef CURSOR_LINE_EDITOR_DEFINES_SVH
`define CURSOR_LINE_EDITOR_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define CLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define CLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cle_pkg.sv =====
// Types and constants shared by the line editor modules.
`timescale 1ns / 1ps

package cle_pkg;

    localparam int CUR_W  = 6;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;

    // Terminal bytes with a meaning
    localparam logic [BYTE_W-1:0] BYTE_DEL   = 8'd127;
    localparam logic [BYTE_W-1:0] BYTE_BS    = 8'd8;
    localparam logic [BYTE_W-1:0] BYTE_NL    = 8'd10;
    localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'd27;
    localparam logic [BYTE_W-1:0] BYTE_LBR   = 8'd91;
    localparam logic [BYTE_W-1:0] BYTE_C     = 8'd67;
    localparam logic [BYTE_W-1:0] BYTE_D     = 8'd68;
    localparam logic [BYTE_W-1:0] BYTE_PRLO  = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_PRHI  = 8'h7E;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_INSERT,
        OP_DELETE,
        OP_RIGHT,
        OP_LEFT,
        OP_COMMIT
    } op_t;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_FIRST,
        ESC_SECOND
    } esc_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_INS_RD,
        B_INS_WR,
        B_INS_PUT,
        B_DEL_RD,
        B_DEL_WR,
        B_CMT_RD,
        B_CMT_PUT,
        B_STATUS
    } bst_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] line_char;
        logic [CUR_W-1:0]  cursor_now;
        logic [CUR_W-1:0]  length_now;
        logic              last_of_run;
    } res_t;

endpackage

// ===== rtl/cle_fifo.sv =====
// Two-entry queue used between front and back and on the result side.
`timescale 1ns / 1ps

module cle_fifo
    import cle_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/cle_front.sv =====
// Front end: tracks escape sequences and turns each byte into an edit command.
`timescale 1ns / 1ps

module cle_front
    import cle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              cmd_full,
    output logic              cmd_push,
    output cmd_t              cmd
);

    esc_t esc_reg;
    esc_t esc_next;
    logic bracket_reg;
    logic bracket_next;
    logic take;

    assign take     = push && !cmd_full;
    assign cmd_push = take;

    // Next escape phase
    always_comb
    begin
        esc_next     = esc_reg;
        bracket_next = bracket_reg;
        if (take)
        begin
            unique case (esc_reg)
                ESC_FIRST:
                begin
                    esc_next     = ESC_SECOND;
                    bracket_next = (in_byte == BYTE_LBR);
                end
                ESC_SECOND:
                begin
                    esc_next     = ESC_IDLE;
                    bracket_next = 1'b0;
                end
                default:
                begin
                    if (in_byte == BYTE_ESC)
                    begin
                        esc_next     = ESC_FIRST;
                        bracket_next = 1'b0;
                    end
                end
            endcase
        end
    end

    // Classify the byte
    always_comb
    begin
        cmd.data = in_byte;
        cmd.op   = OP_NOP;
        unique case (esc_reg)
            ESC_FIRST:
            begin
                cmd.op = OP_NOP;
            end
            ESC_SECOND:
            begin
                if (bracket_reg && in_byte == BYTE_C)
                begin
                    cmd.op = OP_RIGHT;
                end
                else if (bracket_reg && in_byte == BYTE_D)
                begin
                    cmd.op = OP_LEFT;
                end
            end
            default:
            begin
                priority if (in_byte == BYTE_NL)
                begin
                    cmd.op = OP_COMMIT;
                end
                else if (in_byte == BYTE_DEL || in_byte == BYTE_BS)
                begin
                    cmd.op = OP_DELETE;
                end
                else if (in_byte >= BYTE_PRLO && in_byte <= BYTE_PRHI)
                begin
                    cmd.op = OP_INSERT;
                end
                else
                begin
                    cmd.op = OP_NOP;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg     <= ESC_IDLE;
            bracket_reg <= 1'b0;
        end
        else
        begin
            esc_reg     <= esc_next;
            bracket_reg <= bracket_next;
        end
    end

endmodule

// ===== rtl/cle_back.sv =====
// Back end: holds the line store, carries out edit commands and emits results.
`timescale 1ns / 1ps

module cle_back
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_empty,
    input  cmd_t cmd,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res
);

    localparam int             AW      = $clog2(LINE_DEPTH);
    localparam logic [AW-1:0]  LEN_MAX = AW'(LINE_DEPTH - 1);

    logic [BYTE_W-1:0] mem [LINE_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    bst_t              state_reg;
    bst_t              state_next;
    logic [AW-1:0]     ptr_reg;
    logic [AW-1:0]     ptr_next;
    logic [AW-1:0]     cursor_reg;
    logic [AW-1:0]     cursor_next;
    logic [AW-1:0]     len_reg;
    logic [AW-1:0]     len_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic [KIND_W-1:0] kind_reg;
    logic [KIND_W-1:0] kind_next;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              last_char;

    assign last_char = (ptr_reg == AW'(len_reg - 1'b1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    unique case (cmd.op)
                        OP_INSERT:
                        begin
                            priority if (len_reg == LEN_MAX)
                                state_next = B_STATUS;
                            else if (len_reg == cursor_reg)
                                state_next = B_INS_PUT;
                            else
                                state_next = B_INS_RD;
                        end
                        OP_DELETE:
                        begin
                            if (cursor_reg == '0 || cursor_reg == len_reg)
                                state_next = B_STATUS;
                            else
                                state_next = B_DEL_RD;
                        end
                        OP_COMMIT:
                        begin
                            if (len_reg == '0)
                                state_next = B_STATUS;
                            else
                                state_next = B_CMT_RD;
                        end
                        default:
                        begin
                            state_next = B_STATUS;
                        end
                    endcase
                end
            end
            B_INS_RD:
            begin
                state_next = B_INS_WR;
            end
            B_INS_WR:
            begin
                state_next = (ptr_reg == cursor_reg) ? B_INS_PUT : B_INS_RD;
            end
            B_INS_PUT:
            begin
                state_next = B_STATUS;
            end
            B_DEL_RD:
            begin
                state_next = B_DEL_WR;
            end
            B_DEL_WR:
            begin
                state_next = last_char ? B_STATUS : B_DEL_RD;
            end
            B_CMT_RD:
            begin
                state_next = B_CMT_PUT;
            end
            B_CMT_PUT:
            begin
                if (!res_full)
                    state_next = last_char ? B_IDLE : B_CMT_RD;
            end
            B_STATUS:
            begin
                if (!res_full)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Datapath and handshake outputs
    always_comb
    begin
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res.kind        = kind_reg;
        res.line_char   = '0;
        res.cursor_now  = CUR_W'(cursor_reg);
        res.length_now  = CUR_W'(len_reg);
        res.last_of_run = 1'b1;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = rdata_reg;
        ptr_next        = ptr_reg;
        cursor_next     = cursor_reg;
        len_next        = len_reg;
        byte_next       = byte_reg;
        kind_next       = kind_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop   = 1'b1;
                    byte_next = cmd.data;
                    kind_next = KIND_STATUS;
                    unique case (cmd.op)
                        OP_INSERT:
                        begin
                            ptr_next = AW'(len_reg - 1'b1);
                        end
                        OP_DELETE:
                        begin
                            ptr_next = cursor_reg;
                            if (cursor_reg != '0 && cursor_reg == len_reg)
                            begin
                                cursor_next = AW'(cursor_reg - 1'b1);
                                len_next    = AW'(len_reg - 1'b1);
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (cursor_reg < len_reg)
                                cursor_next = AW'(cursor_reg + 1'b1);
                        end
                        OP_LEFT:
                        begin
                            if (cursor_reg != '0)
                                cursor_next = AW'(cursor_reg - 1'b1);
                        end
                        OP_COMMIT:
                        begin
                            ptr_next = '0;
                            if (len_reg == '0)
                                kind_next = KIND_EMPTY;
                        end
                        default:
                        begin
                            ptr_next = ptr_reg;
                        end
                    endcase
                end
            end
            B_INS_RD, B_DEL_RD, B_CMT_RD:
            begin
                rd_en = 1'b1;
            end
            B_INS_WR:
            begin
                // Shift one byte up, walking down toward the cursor
                wr_en   = 1'b1;
                wr_addr = AW'(ptr_reg + 1'b1);
                if (ptr_reg != cursor_reg)
                    ptr_next = AW'(ptr_reg - 1'b1);
            end
            B_INS_PUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = cursor_reg;
                wr_data     = byte_reg;
                cursor_next = AW'(cursor_reg + 1'b1);
                len_next    = AW'(len_reg + 1'b1);
            end
            B_DEL_WR:
            begin
                // Shift one byte down, walking up toward the end
                wr_en   = 1'b1;
                wr_addr = AW'(ptr_reg - 1'b1);
                if (last_char)
                begin
                    cursor_next = AW'(cursor_reg - 1'b1);
                    len_next    = AW'(len_reg - 1'b1);
                end
                else
                begin
                    ptr_next = AW'(ptr_reg + 1'b1);
                end
            end
            B_CMT_PUT:
            begin
                res.kind        = KIND_CHAR;
                res.line_char   = rdata_reg;
                res.last_of_run = last_char;
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (last_char)
                    begin
                        cursor_next = '0;
                        len_next    = '0;
                    end
                    else
                    begin
                        ptr_next = AW'(ptr_reg + 1'b1);
                    end
                end
            end
            B_STATUS:
            begin
                res_push = !res_full;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            cursor_reg <= '0;
            len_reg    <= '0;
            kind_reg   <= KIND_STATUS;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            len_reg    <= len_next;
            kind_reg   <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        byte_reg <= byte_next;
    end

    // Line store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/cursor_line_editor.sv =====
// Cursor line editor: a front end that decodes terminal bytes feeds the editing back end through
// a two-entry command queue. Each accepted byte yields one status beat, except newline, which
// yields one beat per line byte (last one marked) or one empty-line beat, then clears the line.
// The back end moves data through a line store of LINE_DEPTH bytes with a read port and a write
// port, one read and one write per moved byte. The line store is not cleared at reset; only
// bytes below the current length are ever read.
// Up to two input beats and two result beats are buffered, so full and empty stall each side.
`timescale 1ns / 1ps

module cursor_line_editor
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              empty,
    input  logic              pop,
    output logic [KIND_W-1:0] kind,
    output logic [BYTE_W-1:0] line_char,
    output logic [CUR_W-1:0]  cursor_now,
    output logic [CUR_W-1:0]  length_now,
    output logic              last_of_run
);

    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_full;
    logic cmd_pop;
    cmd_t cmd_out;
    logic cmd_empty;
    logic res_push;
    res_t res_in;
    logic res_full;
    res_t res_out;

    assign full = cmd_full;

    cle_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_byte  (in_byte),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    cle_fifo #(.WIDTH($bits(cmd_t))) u_cmd_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    cle_back #(.LINE_DEPTH(LINE_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    cle_fifo #(.WIDTH($bits(res_t))) u_res_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign kind        = res_out.kind;
    assign line_char   = res_out.line_char;
    assign cursor_now  = res_out.cursor_now;
    assign length_now  = res_out.length_now;
    assign last_of_run = res_out.last_of_run;

endmodule

// ===== rtl/cle_checker.sv =====
// Port-level checks for the line editor, bound to the top level.
`timescale 1ns / 1ps
`include "cursor_line_editor_defines.svh"

module cle_checker
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = 64
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input logic [KIND_W-1:0] kind,
    input logic [BYTE_W-1:0] line_char,
    input logic [CUR_W-1:0]  cursor_now,
    input logic [CUR_W-1:0]  length_now,
    input logic              last_of_run
);

    localparam logic [CUR_W-1:0] LEN_MAX = CUR_W'(LINE_DEPTH - 1);

    // A waiting result beat holds until popped
    `CLE_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(kind) && $stable(line_char) && $stable(last_of_run), "result beat changed while waiting")

    // Cursor never passes the end and the line never overfills
    `CLE_ASSERT_IMP(a_bounds, clk, rst_n, !empty, cursor_now <= length_now && length_now <= LEN_MAX, "cursor or length out of range")

    // Only line bytes carry a character, and other beats end their run
    `CLE_ASSERT_IMP(a_status, clk, rst_n, !empty && kind != KIND_CHAR, line_char == '0 && last_of_run && (kind == KIND_STATUS || kind == KIND_EMPTY), "bad status beat")

    // An empty-line beat reports an empty line
    `CLE_ASSERT_IMP(a_empty, clk, rst_n, !empty && kind == KIND_EMPTY, length_now == '0 && cursor_now == '0, "empty commit with nonzero length")

endmodule

bind cursor_line_editor cle_checker #(.LINE_DEPTH(LINE_DEPTH)) u_cle_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .line_char   (line_char),
    .cursor_now  (cursor_now),
    .length_now  (length_now),
    .last_of_run (last_of_run)
);

// ===== verif/line_edit_checker.sv =====
// Checker for the cursor line editor: predicts result beats from accepted bytes and compares.
`timescale 1ns / 1ps

module line_edit_checker
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              empty,
    input  logic              pop,
    input  logic [KIND_W-1:0] kind,
    input  logic [BYTE_W-1:0] line_char,
    input  logic [CUR_W-1:0]  cursor_now,
    input  logic [CUR_W-1:0]  length_now,
    input  logic              last_of_run,
    output int                mismatch_count,
    output int                beats_due
);

    // Result beats still owed by the block, oldest first
    res_t pending_results[$];
    res_t want;

    // Shadow copy of the editor state
    logic [BYTE_W-1:0] line_buf [LINE_DEPTH];
    int                line_len;
    int                cur_pos;
    esc_t              esc_state;
    logic              esc_bracket;
    int                beat_no;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic expect_beat(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] ch,
                               input logic last);
        res_t r;
        r.kind        = k;
        r.line_char   = ch;
        r.cursor_now  = cur_pos[CUR_W-1:0];
        r.length_now  = line_len[CUR_W-1:0];
        r.last_of_run = last;
        pending_results.push_back(r);
    endtask

    // Apply one terminal byte to the shadow line and queue the beats it causes
    task automatic edit_line(input logic [BYTE_W-1:0] b);
        int i;
        case (esc_state)
            ESC_FIRST:
            begin
                esc_bracket = (b == BYTE_LBR);
                esc_state   = ESC_SECOND;
            end
            ESC_SECOND:
            begin
                // only ESC [ C and ESC [ D move the cursor, and never past an end
                if (esc_bracket)
                begin
                    if (b == BYTE_C && cur_pos < line_len)
                        cur_pos++;
                    else if (b == BYTE_D && cur_pos > 0)
                        cur_pos--;
                end
                esc_state   = ESC_IDLE;
                esc_bracket = 1'b0;
            end
            default:
            begin
                if (b == BYTE_NL)
                begin
                    // commit the line byte by byte, then clear the editor
                    if (line_len == 0)
                        expect_beat(KIND_EMPTY, '0, 1'b1);
                    else
                        for (i = 0; i < line_len && i < LINE_DEPTH - 1; i++)
                            expect_beat(KIND_CHAR, line_buf[i], (i + 1 == line_len));
                    line_len = 0;
                    cur_pos  = 0;
                    return;
                end
                else if (b == BYTE_ESC)
                begin
                    esc_state   = ESC_FIRST;
                    esc_bracket = 1'b0;
                end
                else if (b == BYTE_DEL || b == BYTE_BS)
                begin
                    // close the gap before the cursor; nothing to do at position 0
                    if (cur_pos > 0)
                    begin
                        for (i = cur_pos; i < line_len; i++)
                            line_buf[i - 1] = line_buf[i];
                        cur_pos--;
                        line_len--;
                    end
                end
                else if (b >= BYTE_PRLO && b <= BYTE_PRHI)
                begin
                    // open a slot at the cursor; drop the byte once the line is full
                    if (line_len + 1 < LINE_DEPTH)
                    begin
                        for (i = line_len; i > cur_pos; i--)
                            line_buf[i] = line_buf[i - 1];
                        line_buf[cur_pos] = b;
                        cur_pos++;
                        line_len++;
                    end
                end
            end
        endcase
        expect_beat(KIND_STATUS, '0, 1'b1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_results.delete();
            line_len       = 0;
            cur_pos        = 0;
            esc_state      = ESC_IDLE;
            esc_bracket    = 1'b0;
            beat_no        = 0;
            mismatch_count = 0;
            beats_due      = 0;
        end
        else
        begin
            // predict on every accepted input beat
            if (push && !full)
                edit_line(in_byte);

            // compare every accepted result beat with the oldest expectation
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("beat %0d arrived with nothing pending", beat_no));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (kind !== want.kind)
                        report_mismatch($sformatf("beat %0d kind: got %0d, want %0d",
                                                  beat_no, kind, want.kind));
                    if (line_char !== want.line_char)
                        report_mismatch($sformatf("beat %0d line_char: got %0d, want %0d",
                                                  beat_no, line_char, want.line_char));
                    if (cursor_now !== want.cursor_now)
                        report_mismatch($sformatf("beat %0d cursor_now: got %0d, want %0d",
                                                  beat_no, cursor_now, want.cursor_now));
                    if (length_now !== want.length_now)
                        report_mismatch($sformatf("beat %0d length_now: got %0d, want %0d",
                                                  beat_no, length_now, want.length_now));
                    if (last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("beat %0d last_of_run: got %0d, want %0d",
                                                  beat_no, last_of_run, want.last_of_run));
                end
                beat_no++;
            end

            beats_due = pending_results.size();
        end
    end

endmodule

// ===== verif/tb_cursor_line_editor.sv =====
// Testbench top for the cursor line editor: clock, reset, byte stimulus and the verdict.
`timescale 1ns / 1ps

module tb_cursor_line_editor;
    import cle_pkg::*;

    localparam int     LINE_DEPTH   = 64;
    localparam int     RANDOM_BYTES = 360;
    localparam int     LONG_HOLD    = 400;
    localparam int     TAIL_CYCLES  = 200;
    localparam longint RUN_LIMIT_NS = 40_000_000;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              push    = 1'b0;
    logic [BYTE_W-1:0] in_byte = '0;
    logic              pop     = 1'b0;
    logic              full;
    logic              empty;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] line_char;
    logic [CUR_W-1:0]  cursor_now;
    logic [CUR_W-1:0]  length_now;
    logic              last_of_run;

    int mismatch_count;
    int beats_due;
    int bytes_sent;

    // Shared knobs: steady turns idling off, a flip of hold_toggle asks for a long receiver hold
    bit steady      = 1'b0;
    bit hold_toggle = 1'b0;

    always #4 clk = ~clk;

    cursor_line_editor #(
        .LINE_DEPTH (LINE_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .line_char   (line_char),
        .cursor_now  (cursor_now),
        .length_now  (length_now),
        .last_of_run (last_of_run)
    );

    line_edit_checker #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .in_byte        (in_byte),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .line_char      (line_char),
        .cursor_now     (cursor_now),
        .length_now     (length_now),
        .last_of_run    (last_of_run),
        .mismatch_count (mismatch_count),
        .beats_due      (beats_due)
    );

    // Mostly short idle stretches, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    // Offer one byte and hold it until the block takes it, then idle for a random gap unless steady
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        push    <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
        gap = steady ? 0 : pick_idle();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_arrow(input logic [BYTE_W-1:0] dir);
        send_byte(BYTE_ESC);
        send_byte(BYTE_LBR);
        send_byte(dir);
    endtask

    function automatic logic [BYTE_W-1:0] any_printable();
        return BYTE_W'($urandom_range(int'(BYTE_PRHI), int'(BYTE_PRLO)));
    endfunction

    // Stop offering bytes until every owed beat has come out
    task automatic wait_for_drain();
        push <= 1'b0;
        @(posedge clk);
        wait (beats_due == 0);
    endtask

    // Result side: random stalls, plus a long counted hold on request
    initial
    begin : result_sink
        int stall_left;
        bit hold_seen;
        stall_left = 0;
        hold_seen  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != hold_seen)
            begin
                hold_seen  = hold_toggle;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = (!steady && $urandom_range(3, 0) == 0) ? pick_idle() : 0;
                pop <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Give up on a hung run
    initial
    begin : run_limit
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int pick;
        int n;
        int i;
        bit drained;
        drained = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty commit, backspace and left at the start, other bytes, edits, escapes
        send_byte(BYTE_NL);
        send_byte(BYTE_BS);
        send_arrow(BYTE_D);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h09);
        send_byte(BYTE_PRLO);
        send_byte(BYTE_PRHI);
        send_byte(8'h61);
        send_arrow(BYTE_D);
        send_byte(BYTE_DEL);
        send_arrow(BYTE_C);
        send_arrow(BYTE_C);
        // unknown pair that swallows a newline, then an ESC swallowed as a first byte
        send_byte(BYTE_ESC);
        send_byte(8'h58);
        send_byte(BYTE_NL);
        send_byte(BYTE_ESC);
        send_byte(BYTE_ESC);
        send_byte(BYTE_D);
        send_byte(BYTE_NL);

        bytes_sent = 0;

        // Fill the line past its end while the receiver holds off, so both sides back up
        hold_toggle <= ~hold_toggle;
        for (i = 0; i < 70; i++)
            send_byte(any_printable());
        send_arrow(BYTE_D);
        send_arrow(BYTE_D);
        send_arrow(BYTE_D);
        send_byte(any_printable());
        send_byte(BYTE_BS);
        send_byte(any_printable());
        send_byte(BYTE_NL);

        // Random edit sessions
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (!drained && bytes_sent >= RANDOM_BYTES / 2)
            begin
                drained = 1'b1;
                wait_for_drain();
            end
            if ($urandom_range(29, 0) == 0)
                steady <= ~steady;

            pick = $urandom_range(99, 0);
            if (pick < 40)
            begin
                n = $urandom_range(8, 1);
                for (i = 0; i < n; i++)
                    send_byte(any_printable());
            end
            else if (pick < 55)
                send_arrow($urandom_range(1, 0) ? BYTE_C : BYTE_D);
            else if (pick < 65)
                send_byte($urandom_range(1, 0) ? BYTE_DEL : BYTE_BS);
            else if (pick < 75)
                send_byte(BYTE_NL);
            else if (pick < 85)
                send_byte(BYTE_W'($urandom_range(255, 0)));
            else if (pick < 93)
            begin
                // broken or random escape sequence
                send_byte(BYTE_ESC);
                send_byte(BYTE_W'($urandom_range(255, 0)));
                send_byte(BYTE_W'($urandom_range(255, 0)));
            end
            else
            begin
                n = $urandom_range(30, 10);
                for (i = 0; i < n; i++)
                    send_byte(any_printable());
            end
        end
        send_byte(BYTE_NL);

        // Let every owed beat out, then watch for strays
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && beats_due == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
